/* src/mrs_pkg.sv */
package mrs_pkg;

  localparam int TABLE_ENTRIES_DEF = 512;
  localparam int MAX_READ_REGS_DEF = 29;
  localparam int FRAME_BYTES_DEF   = 15;

  localparam logic [1:0] FUNC_RX    = 2'd0;
  localparam logic [1:0] FUNC_GAP   = 2'd1;
  localparam logic [1:0] FUNC_NODE  = 2'd2;
  localparam logic [1:0] FUNC_POWER = 2'd3;

  localparam logic [1:0] CHAN_ONE = 2'd1;
  localparam logic [1:0] CHAN_TWO = 2'd2;

  localparam logic [15:0] TABLE_BASE     = 16'h2710;
  localparam logic [15:0] CH2_OFFSET     = 16'd256;
  localparam logic [7:0]  FC_READ        = 8'h03;
  localparam logic [7:0]  FC_WRITE       = 8'h06;
  localparam logic [7:0]  REG_MAIN       = 8'h34;
  localparam logic [7:0]  REG_BACKUP     = 8'h35;
  localparam logic [7:0]  CMD_RESET_ADDR = 8'h32;
  localparam logic [7:0]  CMD_MUTE_ADDR  = 8'h33;
  localparam logic [7:0]  POWER_BCNT     = 8'h23;
  localparam logic [7:0]  HOST_RESET     = 8'h01;
  localparam logic [1:0]  PWR_BAD        = 2'd2;
  localparam logic [15:0] CRC_INIT       = 16'hFFFF;
  localparam logic [15:0] CRC_POLY       = 16'hA001;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_POWER,
    KIND_TABLE,
    KIND_ECHO
  } kind_e;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] rx_byte;
    logic [1:0] channel;
    logic [8:0] node_id;
    logic [7:0] node_state;
    logic       main_ok;
    logic       backup_ok;
  } in_word_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       last_byte;
    logic       reset_pulse;
    logic       mute_pulse;
  } out_word_t;

  typedef struct packed {
    logic  clr;
    logic  take;
    logic  crc_init;
    logic  chk;
    logic  decide;
    logic  fetch;
    logic  send;
    kind_e kind;
  } ctl_cmd_t;

  typedef struct packed {
    logic  clr_last;
    logic  chk_last;
    logic  out_free;
    logic  reply_last;
    kind_e kind;
  } dp_stat_t;

  function automatic logic [15:0] crc_byte(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) c = (c >> 1) ^ CRC_POLY;
      else      c = c >> 1;
    end
    return c;
  endfunction

endpackage

/* src/mrs_datapath.sv */
module mrs_datapath #(
  parameter int TABLE_ENTRIES = mrs_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_READ_REGS = mrs_pkg::MAX_READ_REGS_DEF,
  parameter int FRAME_BYTES   = mrs_pkg::FRAME_BYTES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mrs_pkg::in_word_t  in_word_i,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i,
  input  mrs_pkg::ctl_cmd_t  cmd_i,
  output mrs_pkg::dp_stat_t  stat_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mrs_pkg::out_word_t out_word_o
);

  localparam int TW = $clog2(TABLE_ENTRIES);
  localparam int LW = $clog2(FRAME_BYTES + 2);
  localparam int IW = $clog2(FRAME_BYTES);

  logic [7:0]    fbuf_q [FRAME_BYTES];
  logic [LW-1:0] flen_q;
  logic [7:0]    tbl_q [TABLE_ENTRIES];
  logic [7:0]    rdata_q;
  logic [1:0]    main_q, backup_q;
  logic [7:0]    host_q;
  logic [15:0]   crc_q, crc_d;
  logic [5:0]    k_q;
  logic [TW-1:0] clr_q;
  logic          out_valid_q;
  mrs_pkg::out_word_t out_q;

  // frame fields
  logic [15:0] start, count, off;
  logic [16:0] span;
  logic        frame_ok, read_ok;
  logic [5:0]  nb, k3;
  logic [7:0]  byte_k, tx_b;
  logic [9:0]  node_idx;
  logic        node_we, tbl_we;
  logic [TW-1:0] waddr, raddr;
  logic [7:0]  wdata;

  assign start = {fbuf_q[2], fbuf_q[3]};
  assign count = {fbuf_q[4], fbuf_q[5]};
  assign off   = (start <= (mrs_pkg::TABLE_BASE + mrs_pkg::CH2_OFFSET))
               ? (start - mrs_pkg::TABLE_BASE)
               : (start - mrs_pkg::TABLE_BASE - mrs_pkg::CH2_OFFSET);
  assign span  = {1'b0, off} + {1'b0, count};
  assign read_ok = (count <= 16'(MAX_READ_REGS)) && (32'(span) <= TABLE_ENTRIES);
  assign frame_ok = (flen_q == LW'(8)) && (fbuf_q[0] == host_q)
                 && (fbuf_q[6] == crc_q[7:0]) && (fbuf_q[7] == crc_q[15:8]);

  always_comb begin
    stat_o.kind = mrs_pkg::KIND_NONE;
    if (frame_ok) begin
      if (fbuf_q[1] == mrs_pkg::FC_READ) begin
        if (fbuf_q[3] == mrs_pkg::REG_MAIN || fbuf_q[3] == mrs_pkg::REG_BACKUP) begin
          stat_o.kind = mrs_pkg::KIND_POWER;
        end else if (read_ok) begin
          stat_o.kind = mrs_pkg::KIND_TABLE;
        end
      end else if (fbuf_q[1] == mrs_pkg::FC_WRITE &&
                   (fbuf_q[3] == mrs_pkg::CMD_RESET_ADDR ||
                    fbuf_q[3] == mrs_pkg::CMD_MUTE_ADDR)) begin
        stat_o.kind = mrs_pkg::KIND_ECHO;
      end
    end
  end

  // bytes before the CRC
  assign nb = (cmd_i.kind == mrs_pkg::KIND_TABLE) ? (6'd3 + {count[4:0], 1'b0}) : 6'd6;
  assign k3 = k_q - 6'd3;
  assign byte_k = fbuf_q[k_q[IW-1:0]];

  always_comb begin
    tx_b = 8'h00;
    if (k_q == nb) begin
      tx_b = crc_q[7:0];
    end else if (k_q == nb + 6'd1) begin
      tx_b = crc_q[15:8];
    end else begin
      case (cmd_i.kind)
        mrs_pkg::KIND_ECHO: tx_b = byte_k;
        mrs_pkg::KIND_POWER: begin
          case (k_q)
            6'd0: tx_b = host_q;
            6'd1: tx_b = mrs_pkg::FC_READ;
            6'd2: tx_b = mrs_pkg::POWER_BCNT;
            6'd3: tx_b = fbuf_q[3];
            6'd5: tx_b = {6'd0, (fbuf_q[3] == mrs_pkg::REG_MAIN) ? main_q : backup_q};
            default: tx_b = 8'h00;
          endcase
        end
        mrs_pkg::KIND_TABLE: begin
          case (k_q)
            6'd0: tx_b = host_q;
            6'd1: tx_b = mrs_pkg::FC_READ;
            6'd2: tx_b = {count[6:0], 1'b0};
            default: tx_b = k_q[0] ? 8'h00 : rdata_q;
          endcase
        end
        default: tx_b = 8'h00;
      endcase
    end
  end

  assign crc_d = mrs_pkg::crc_byte(crc_q, cmd_i.chk ? byte_k : tx_b);

  assign stat_o.clr_last   = (32'(clr_q) == TABLE_ENTRIES - 1);
  assign stat_o.chk_last   = (k_q == 6'd5);
  assign stat_o.out_free   = !out_valid_q || !out_stall_i;
  assign stat_o.reply_last = (k_q == nb + 6'd1);

  // table port: clear sweep or node write
  assign node_idx = {1'b0, in_word_i.node_id} - 10'd1
                  + ((in_word_i.channel == mrs_pkg::CHAN_TWO) ? 10'd256 : 10'd0);
  assign node_we = cmd_i.take && (in_word_i.func == mrs_pkg::FUNC_NODE)
                && (in_word_i.node_id >= 9'd1) && (in_word_i.node_id <= 9'd256)
                && (in_word_i.channel == mrs_pkg::CHAN_ONE ||
                    in_word_i.channel == mrs_pkg::CHAN_TWO)
                && (32'(node_idx) < TABLE_ENTRIES);
  assign tbl_we = cmd_i.clr || node_we;
  assign waddr  = cmd_i.clr ? clr_q : TW'(node_idx);
  assign wdata  = cmd_i.clr ? 8'h00 : in_word_i.node_state;
  assign raddr  = TW'(off + {11'd0, k3[5:1]});

  always_ff @(posedge clk_i) begin
    if (tbl_we) tbl_q[waddr] <= wdata;
    if (cmd_i.fetch) rdata_q <= tbl_q[raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take && in_word_i.func == mrs_pkg::FUNC_RX && flen_q < LW'(FRAME_BYTES)) begin
      fbuf_q[flen_q[IW-1:0]] <= in_word_i.rx_byte;
    end
    if (cmd_i.send && stat_o.out_free) out_q <= '{
      tx_byte:     tx_b,
      last_byte:   stat_o.reply_last,
      reset_pulse: (cmd_i.kind == mrs_pkg::KIND_ECHO) &&
                   (fbuf_q[3] == mrs_pkg::CMD_RESET_ADDR),
      mute_pulse:  (cmd_i.kind == mrs_pkg::KIND_ECHO) &&
                   (fbuf_q[3] == mrs_pkg::CMD_MUTE_ADDR)
    };
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flen_q      <= '0;
      main_q      <= '0;
      backup_q    <= '0;
      host_q      <= mrs_pkg::HOST_RESET;
      crc_q       <= mrs_pkg::CRC_INIT;
      k_q         <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) host_q <= cfg_wdata_i;
      if (cmd_i.clr) clr_q <= clr_q + TW'(1);
      if (cmd_i.take) begin
        if (in_word_i.func == mrs_pkg::FUNC_RX) begin
          flen_q <= (flen_q < LW'(FRAME_BYTES)) ? flen_q + LW'(1) : LW'(FRAME_BYTES + 1);
        end
        if (in_word_i.func == mrs_pkg::FUNC_POWER) begin
          main_q   <= in_word_i.main_ok   ? 2'd0 : mrs_pkg::PWR_BAD;
          backup_q <= in_word_i.backup_ok ? 2'd0 : mrs_pkg::PWR_BAD;
        end
      end
      if (cmd_i.crc_init || cmd_i.decide) begin
        crc_q <= mrs_pkg::CRC_INIT;
        k_q   <= '0;
      end else if (cmd_i.chk || (cmd_i.send && stat_o.out_free)) begin
        // CRC stays frozen while its own two bytes go out
        if (cmd_i.chk || k_q < nb) crc_q <= crc_d;
        k_q   <= k_q + 6'd1;
      end
      if (cmd_i.decide) flen_q <= '0;
      if (cmd_i.send && stat_o.out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

/* src/mrs_ctrl.sv */
module mrs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        in_func_i,
  output logic              in_stall_o,
  input  mrs_pkg::dp_stat_t stat_i,
  output mrs_pkg::ctl_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_DECIDE,
    ST_FETCH,
    ST_SEND
  } state_e;

  state_e         state_q;
  mrs_pkg::kind_e kind_q;
  logic           take;

  assign in_stall_o = (state_q != ST_IDLE);
  assign take       = in_valid_i && (state_q == ST_IDLE);

  always_comb begin
    cmd_o          = '0;
    cmd_o.kind     = kind_q;
    cmd_o.clr      = (state_q == ST_CLEAR);
    cmd_o.take     = take;
    cmd_o.crc_init = take && (in_func_i == mrs_pkg::FUNC_GAP);
    cmd_o.chk      = (state_q == ST_CHECK);
    cmd_o.decide   = (state_q == ST_DECIDE);
    cmd_o.fetch    = (state_q == ST_FETCH);
    cmd_o.send     = (state_q == ST_SEND);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      kind_q  <= mrs_pkg::KIND_NONE;
    end else begin
      case (state_q)
        ST_CLEAR:  if (stat_i.clr_last) state_q <= ST_IDLE;
        ST_IDLE:   if (take && in_func_i == mrs_pkg::FUNC_GAP) state_q <= ST_CHECK;
        ST_CHECK:  if (stat_i.chk_last) state_q <= ST_DECIDE;
        ST_DECIDE: begin
          kind_q  <= stat_i.kind;
          state_q <= (stat_i.kind == mrs_pkg::KIND_NONE) ? ST_IDLE : ST_FETCH;
        end
        ST_FETCH:  state_q <= ST_SEND;
        ST_SEND: begin
          if (stat_i.out_free) state_q <= stat_i.reply_last ? ST_IDLE : ST_FETCH;
        end
        default:   state_q <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_fetch_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FETCH |=> state_q == ST_SEND) else $error("fetch not followed by send");
  a_check_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CHECK && stat_i.chk_last |=> state_q == ST_DECIDE)
    else $error("crc check overran");
  a_send_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SEND |-> kind_q != mrs_pkg::KIND_NONE) else $error("reply without kind");
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SEND && stat_i.out_free && stat_i.reply_last |=> state_q == ST_IDLE)
    else $error("reply did not end");
`endif

endmodule

/* src/modbus_rtu_status_slave_unit.sv */
// Modbus RTU status slave.
// Input channel (in_valid_i / in_stall_o) carries one word per event: a
// received byte, a frame gap, a node-state write or a power update.
// Output channel (out_valid_o / out_stall_i) carries reply bytes, CRC low
// byte first, last_byte set on the final byte.
// Byte, node and power words are taken in the idle state and leave it idle.
// A frame gap starts the CRC check over the received bytes (ST_CHECK), then
// ST_DECIDE picks the reply; each reply byte then passes through ST_FETCH
// (table read port access) and ST_SEND (CRC update and load of the output
// register). The CRC unit folds in one byte per cycle during the check.
// No input is taken while a reply is generated. When the receiver stalls,
// the output register holds its word and generation waits on it.
// After reset the status table is swept to zero, one entry per cycle, over
// all TABLE_ENTRIES entries; in_stall_o stays high until it is done. Writes of
// host_address are taken at any time and reset to 1.
module modbus_rtu_status_slave_unit #(
  parameter int TABLE_ENTRIES = mrs_pkg::TABLE_ENTRIES_DEF,
  parameter int MAX_READ_REGS = mrs_pkg::MAX_READ_REGS_DEF,
  parameter int FRAME_BYTES   = mrs_pkg::FRAME_BYTES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mrs_pkg::in_word_t  in_word_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mrs_pkg::out_word_t out_word_o,
  input  logic               cfg_we_i,
  input  logic [7:0]         cfg_wdata_i
);

  mrs_pkg::ctl_cmd_t cmd;
  mrs_pkg::dp_stat_t stat;

  mrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_func_i  (in_word_i.func),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mrs_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .MAX_READ_REGS (MAX_READ_REGS),
    .FRAME_BYTES   (FRAME_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_word_i   (in_word_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule
